// ===== hw/rtl/smd_pkg.sv =====
// Shared constants and elaboration-time sRGB linearization tables for the mip downsampler.
package smd_pkg;

  localparam int unsigned LinFracBitsDef = 16;
  localparam int unsigned LinFracBitsMax = 24;
  localparam int unsigned LinMaxW        = LinFracBitsMax + 1;
  localparam int unsigned ThrMaxW        = LinFracBitsMax + 3;
  localparam int unsigned WideW          = 320;
  localparam int unsigned SrgbDenom      = 10761;
  localparam int unsigned NumCodes       = 256;

  typedef logic [LinMaxW-1:0] lin_tab_t [NumCodes];
  typedef logic [ThrMaxW-1:0] thr_tab_t [NumCodes];

  // Exact round(linear(i) * 2^frac_bits); linear toe below code 11, power curve above.
  function automatic lin_tab_t build_lin(input int unsigned frac_bits);
    lin_tab_t         tab;
    logic [WideW-1:0] den12;
    logic [WideW-1:0] rhs;
    logic [WideW-1:0] lhs;
    logic [63:0]      num;
    logic [31:0]      lo;
    logic [31:0]      hi;
    logic [31:0]      mid;
    logic [31:0]      n;
    int unsigned      i;
    int unsigned      r;
    den12 = WideW'(1);
    for (r = 0; r < 12; r++) begin
      den12 = den12 * WideW'(SrgbDenom);
    end
    for (i = 0; i < NumCodes; i++) begin
      if (i <= 10) begin
        num    = 64'(10 * i) * (64'd1 << frac_bits) + 64'd16473;
        tab[i] = LinMaxW'(num / 64'd32946);
      end else begin
        n   = 32'(40 * i + 561);
        rhs = WideW'(1);
        for (r = 0; r < 12; r++) begin
          rhs = rhs * WideW'(n);
        end
        rhs = rhs << (5 * frac_bits + 5);
        lo  = '0;
        hi  = 32'd1 << frac_bits;
        // Largest k with (2k-1)^5 * D^12 <= 32 * n^12 * 2^(5F)
        while (lo < hi) begin
          mid = (lo + hi + 32'd1) >> 1;
          lhs = den12;
          for (r = 0; r < 5; r++) begin
            lhs = lhs * WideW'(2 * mid - 32'd1);
          end
          if (lhs <= rhs) begin
            lo = mid;
          end else begin
            hi = mid - 32'd1;
          end
        end
        tab[i] = LinMaxW'(lo);
      end
    end
    return tab;
  endfunction

  // Decision thresholds: four times the midpoint between codes m and m+1.
  function automatic thr_tab_t build_thr(input int unsigned frac_bits);
    lin_tab_t    lin;
    thr_tab_t    thr;
    int unsigned m;
    lin = build_lin(frac_bits);
    for (m = 0; m < NumCodes - 1; m++) begin
      thr[m] = (ThrMaxW'(lin[m]) + ThrMaxW'(lin[m+1])) << 1;
    end
    thr[NumCodes-1] = '1;
    return thr;
  endfunction

endpackage

// ===== hw/rtl/smd_linearize.sv =====
// Front stages: sRGB-to-linear lookup and alpha average, then the four-way linear sum.
module smd_linearize #(
  parameter int unsigned LinearFractionBits = smd_pkg::LinFracBitsDef,
  parameter int unsigned LinW               = LinearFractionBits + 1,
  parameter int unsigned SumW               = LinearFractionBits + 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_a_i,
  input  logic                     en_b_i,
  input  logic [31:0]              top_left_i,
  input  logic [31:0]              top_right_i,
  input  logic [31:0]              bottom_left_i,
  input  logic [31:0]              bottom_right_i,
  output logic [2:0][SumW-1:0]     sum_o,
  output logic [7:0]               alpha_o
);

  localparam smd_pkg::lin_tab_t LinTab = smd_pkg::build_lin(LinearFractionBits);

  logic [2:0][3:0][LinW-1:0] lin_d, lin_q;
  logic [7:0]                alpha_d, alpha_a_q, alpha_b_q;
  logic [2:0][SumW-1:0]      sum_d, sum_q;
  logic [9:0]                alpha_sum;
  logic [3:0][31:0]          px;

  assign px = {bottom_right_i, bottom_left_i, top_right_i, top_left_i};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        lin_d[c][k] = LinTab[px[k][8*c +: 8]][LinW-1:0];
      end
    end
    alpha_sum = 10'(px[0][31:24]) + 10'(px[1][31:24]) + 10'(px[2][31:24])
              + 10'(px[3][31:24]) + 10'd2;
    alpha_d   = alpha_sum[9:2];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = SumW'(lin_q[c][0]) + SumW'(lin_q[c][1])
               + SumW'(lin_q[c][2]) + SumW'(lin_q[c][3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q     <= '0;
      alpha_a_q <= '0;
      sum_q     <= '0;
      alpha_b_q <= '0;
    end else begin
      if (en_a_i) begin
        lin_q     <= lin_d;
        alpha_a_q <= alpha_d;
      end
      if (en_b_i) begin
        sum_q     <= sum_d;
        alpha_b_q <= alpha_a_q;
      end
    end
  end

  assign sum_o   = sum_q;
  assign alpha_o = alpha_b_q;

endmodule

// ===== hw/rtl/smd_search_step.sv =====
// One stage of the output code search: settles one bit of each color code.
module smd_search_step #(
  parameter int unsigned LinearFractionBits = smd_pkg::LinFracBitsDef,
  parameter int unsigned SumW               = LinearFractionBits + 3,
  parameter int unsigned Bit                = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [2:0][SumW-1:0] sum_i,
  input  logic [2:0][7:0]      code_i,
  input  logic [7:0]           alpha_i,
  output logic [2:0][SumW-1:0] sum_o,
  output logic [2:0][7:0]      code_o,
  output logic [7:0]           alpha_o
);

  localparam smd_pkg::thr_tab_t ThrTab = smd_pkg::build_thr(LinearFractionBits);

  logic [2:0][7:0]      code_d, code_q;
  logic [2:0][7:0]      cand;
  logic [2:0][7:0]      idx;
  logic [2:0][SumW-1:0] sum_q;
  logic [7:0]           alpha_q;

  // Code is the count of thresholds the sum exceeds; try setting this bit.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cand[c] = code_i[c] | (8'd1 << Bit);
      idx[c]  = cand[c] - 8'd1;
      if (sum_i[c] > ThrTab[idx[c]][SumW-1:0]) begin
        code_d[c] = cand[c];
      end else begin
        code_d[c] = code_i[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      code_q  <= '0;
      alpha_q <= '0;
    end else if (en_i) begin
      sum_q   <= sum_i;
      code_q  <= code_d;
      alpha_q <= alpha_i;
    end
  end

  assign sum_o   = sum_q;
  assign code_o  = code_q;
  assign alpha_o = alpha_q;

endmodule

// ===== hw/rtl/srgb_mip_downsample.sv =====
// Gamma-correct 2x2 box mip downsampler: top level with the pipeline handshake.
//
// Input channel: in_valid_i / in_stall_o with the four RGBA8 pixels of a quad
// (R in bits 7:0, G 15:8, B 23:16, alpha 31:24). A transfer happens on a rising
// edge with valid high and stall low. Output channel: out_valid_o / out_stall_i
// with mip_pixel_o in the same packing.
// Alpha is the rounded average. Each color channel is linearized by a table,
// summed, and mapped back by an eight-step threshold search, one bit per stage.
// Stages are lookup, sum, then eight search stages, 10 in all. Throughput is
// one quad per cycle while out_stall_i is low. Every stage carries a valid bit;
// a constant-table read plus a compare per channel sets each search stage depth.
// When the receiver stalls, the result holds on the output and the stages
// behind it keep filling bubbles; in_stall_o rises only once all stages hold
// data. Reset clears every valid bit; the tables are constants and need no fill.
module srgb_mip_downsample #(
  parameter int unsigned LinearFractionBits = smd_pkg::LinFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] top_left_i,
  input  logic [31:0] top_right_i,
  input  logic [31:0] bottom_left_i,
  input  logic [31:0] bottom_right_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] mip_pixel_o
);

  localparam int unsigned SumW      = LinearFractionBits + 3;
  localparam int unsigned NumSteps  = 8;
  localparam int unsigned NumStages = NumSteps + 2;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] en;

  logic [2:0][SumW-1:0] sum_s   [NumSteps+1];
  logic [2:0][7:0]      code_s  [NumSteps+1];
  logic [7:0]           alpha_s [NumSteps+1];

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  smd_linearize #(
    .LinearFractionBits(LinearFractionBits)
  ) u_linearize (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_a_i        (en[0]),
    .en_b_i        (en[1]),
    .top_left_i    (top_left_i),
    .top_right_i   (top_right_i),
    .bottom_left_i (bottom_left_i),
    .bottom_right_i(bottom_right_i),
    .sum_o         (sum_s[0]),
    .alpha_o       (alpha_s[0])
  );

  assign code_s[0] = '0;

  for (genvar j = 0; j < NumSteps; j++) begin : g_step
    smd_search_step #(
      .LinearFractionBits(LinearFractionBits),
      .Bit               (NumSteps - 1 - j)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[j+2]),
      .sum_i  (sum_s[j]),
      .code_i (code_s[j]),
      .alpha_i(alpha_s[j]),
      .sum_o  (sum_s[j+1]),
      .code_o (code_s[j+1]),
      .alpha_o(alpha_s[j+1])
    );
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign mip_pixel_o = {alpha_s[NumSteps], code_s[NumSteps][2], code_s[NumSteps][1],
                        code_s[NumSteps][0]};

`ifndef NO_ASSERTIONS
  // Input may stall only when every stage holds an item.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // A free output lets the whole pipeline advance.
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // An accepted quad lands in the first stage.
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted quad lost at pipeline entry");
`endif

endmodule

// ===== dv/mip_checker.sv =====
// Scoreboard for the mip downsampler: watches both channels, predicts each pixel and compares.
module mip_checker #(
  parameter int unsigned FracBits = smd_pkg::LinFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] top_left_i,
  input  logic [31:0] top_right_i,
  input  logic [31:0] bottom_left_i,
  input  logic [31:0] bottom_right_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] mip_pixel_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotBits = 6;
  localparam int unsigned Slots    = 1 << SlotBits;

  logic [31:0]         lin_lut [256];
  logic [31:0]         expected_mem [Slots];
  logic [SlotBits-1:0] wr_ptr = '0;
  logic [SlotBits-1:0] rd_ptr = '0;
  int unsigned         held = 0;
  int unsigned         errors = 0;
  int unsigned         checked = 0;

  assign error_count_o = errors;
  assign pending_o     = held;
  assign compared_o    = checked;

  // round(linear(code) * 2^FracBits); the power segment is solved exactly by a bitwise search
  // for the largest k with (2k-1)^5 * 10761^12 <= 32 * (40*code+561)^12 * 2^(5*FracBits).
  function automatic void build_linear_lut();
    logic [319:0] den_pow;
    logic [319:0] rhs;
    logic [319:0] lhs;
    logic [31:0]  k;
    logic [31:0]  cand;
    int unsigned  code;
    int unsigned  r;
    int           b;
    den_pow = 320'd1;
    for (r = 0; r < 12; r++) begin
      den_pow = den_pow * 320'd10761;
    end
    for (code = 0; code < 256; code++) begin
      if (code <= 10) begin
        lin_lut[code] = 32'((64'(code) * 64'd10 * (64'd1 << FracBits) + 64'd16473) / 64'd32946);
      end else begin
        rhs = 320'd1;
        for (r = 0; r < 12; r++) begin
          rhs = rhs * 320'(40 * code + 561);
        end
        rhs = rhs << (5 * FracBits + 5);
        k = '0;
        for (b = FracBits; b >= 0; b--) begin
          cand = k | (32'd1 << b);
          if (cand <= (32'd1 << FracBits)) begin
            lhs = den_pow;
            for (r = 0; r < 5; r++) begin
              lhs = lhs * 320'(2 * cand - 32'd1);
            end
            if (lhs <= rhs) begin
              k = cand;
            end
          end
        end
        lin_lut[code] = k;
      end
    end
  endfunction

  initial build_linear_lut();

  // Smallest code whose midpoint with the next code is not below the average; ties stay low.
  function automatic logic [7:0] encode_channel(logic [31:0] lin_sum);
    for (int m = 0; m < 255; m++) begin
      if (!(lin_sum > ((lin_lut[m] + lin_lut[m+1]) << 1))) begin
        return 8'(m);
      end
    end
    return 8'd255;
  endfunction

  function automatic logic [31:0] predict_mip_pixel(logic [31:0] tl, logic [31:0] tr,
                                                     logic [31:0] bl, logic [31:0] br);
    logic [31:0] px;
    logic [31:0] lin_sum;
    logic [9:0]  alpha_sum;
    for (int c = 0; c < 3; c++) begin
      lin_sum = lin_lut[tl[8*c +: 8]] + lin_lut[tr[8*c +: 8]]
              + lin_lut[bl[8*c +: 8]] + lin_lut[br[8*c +: 8]];
      px[8*c +: 8] = encode_channel(lin_sum);
    end
    alpha_sum = 10'(tl[31:24]) + 10'(tr[31:24]) + 10'(bl[31:24]) + 10'(br[31:24]) + 10'd2;
    px[31:24] = alpha_sum[9:2];
    return px;
  endfunction

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expected_mem[wr_ptr] = predict_mip_pixel(top_left_i, top_right_i,
                                                 bottom_left_i, bottom_right_i);
        wr_ptr = wr_ptr + 1'b1;
        held++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (held == 0) begin
          $display("%0t mip_checker: unexpected mip_pixel %h, expected none", $time,
                   mip_pixel_i);
          errors++;
        end else begin
          want   = expected_mem[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          held--;
          checked++;
          if (mip_pixel_i !== want) begin
            $display("%0t mip_checker: mip_pixel expected %h actual %h", $time, want,
                     mip_pixel_i);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the mip downsampler: clock, reset, quad stimulus, result sink and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits    = smd_pkg::LinFracBitsDef;
  localparam int unsigned RandomQuads = 800;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] top_left = '0;
  logic [31:0] top_right = '0;
  logic [31:0] bottom_left = '0;
  logic [31:0] bottom_right = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] mip_pixel;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;
  int unsigned quads_sent = 0;
  int unsigned directed_quads = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  srgb_mip_downsample #(
    .LinearFractionBits(FracBits)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .top_left_i    (top_left),
    .top_right_i   (top_right),
    .bottom_left_i (bottom_left),
    .bottom_right_i(bottom_right),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .mip_pixel_o   (mip_pixel)
  );

  mip_checker #(
    .FracBits(FracBits)
  ) checker_inst (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .top_left_i    (top_left),
    .top_right_i   (top_right),
    .bottom_left_i (bottom_left),
    .bottom_right_i(bottom_right),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .mip_pixel_i   (mip_pixel),
    .error_count_o (mismatches),
    .pending_o     (outstanding),
    .compared_o    (compared)
  );

  // Called at a rising edge; returns at the edge where the quad transfers.
  task automatic send_quad(input logic [31:0] tl, input logic [31:0] tr,
                           input logic [31:0] bl, input logic [31:0] br);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    top_left     <= tl;
    top_right    <= tr;
    bottom_left  <= bl;
    bottom_right <= br;
    in_valid     <= 1'b1;
    // stall is settled by the falling edge
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    quads_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic void pick_random_quad(output logic [31:0] p0, output logic [31:0] p1,
                                           output logic [31:0] p2, output logic [31:0] p3);
    logic [31:0] px [4];
    logic [31:0] hi_px;
    logic [31:0] r;
    logic [31:0] swap;
    logic [7:0]  lo;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    for (int n = 0; n < 4; n++) begin
      px[n] = $urandom;
    end
    if (kind < 35) begin
      // fully random quad
    end else if (kind < 55) begin
      // near-flat: small differences around one pixel
      for (int n = 1; n < 4; n++) begin
        px[n] = px[0] ^ ($urandom & 32'h03030303);
      end
    end else if (kind < 68) begin
      // linear toe and the knee of the curve
      for (int n = 0; n < 4; n++) begin
        px[n] = px[n] & 32'hFF0F0F0F;
      end
    end else if (kind < 76) begin
      for (int n = 1; n < 4; n++) begin
        px[n] = px[0];
      end
    end else if (kind < 90) begin
      // two of code m and two of m+1 land exactly on the midpoint
      hi_px = $urandom;
      for (int c = 0; c < 3; c++) begin
        lo = 8'($urandom_range(0, 254));
        px[0][8*c +: 8] = lo;
        hi_px[8*c +: 8] = lo + 8'd1;
      end
      px[1] = px[0];
      px[2] = hi_px;
      px[3] = hi_px;
      if ($urandom_range(0, 1) == 1) begin
        swap = px[1];
        px[1] = px[2];
        px[2] = swap;
      end
      if ($urandom_range(0, 1) == 1) begin
        swap = px[0];
        px[0] = px[3];
        px[3] = swap;
      end
    end else begin
      // every byte one of 0, 1, 254, 255
      for (int n = 0; n < 4; n++) begin
        r = $urandom;
        for (int c = 0; c < 4; c++) begin
          px[n][8*c +: 8] = {8{r[2*c]}} ^ {7'd0, r[2*c+1]};
        end
      end
    end
    p0 = px[0];
    p1 = px[1];
    p2 = px[2];
    p3 = px[3];
  endfunction

  // Result sink: hold off a random number of cycles, then take one result.
  initial begin : result_sink
    int unsigned hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("%0t watchdog: %0d cycles without a transfer, %0d results outstanding",
               $time, IdleLimit, outstanding);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] q0;
    logic [31:0] q1;
    logic [31:0] q2;
    logic [31:0] q3;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_quad(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
    send_quad(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_quad(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000);
    send_quad(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_quad(32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00);
    // flat quads come back unchanged
    send_quad(32'h80C04020, 32'h80C04020, 32'h80C04020, 32'h80C04020);
    send_quad(32'h0A0B0C0D, 32'h0A0B0C0D, 32'h0A0B0C0D, 32'h0A0B0C0D);
    send_quad(32'hFE01FE01, 32'hFE01FE01, 32'hFE01FE01, 32'hFE01FE01);
    // toe/power boundary between codes 10 and 11
    send_quad(32'h0A0A0A0A, 32'h0B0B0B0B, 32'h0A0A0A0A, 32'h0B0B0B0B);
    send_quad(32'h01010101, 32'h00000000, 32'h00000000, 32'h00000000);
    // exact midpoint ties resolve to the lower code
    send_quad(32'h40404040, 32'h41414141, 32'h40404040, 32'h41414141);
    send_quad(32'h007F0A00, 32'h007F0A00, 32'h01800B01, 32'h01800B01);
    send_quad(32'h00FEFEFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00FEFEFE);
    // alpha rounding: 1/4 down, 2/4 up, 3/4 up
    send_quad(32'h00000000, 32'h00000000, 32'h00000000, 32'h01000000);
    send_quad(32'h00000000, 32'h00000000, 32'h00000000, 32'h02000000);
    send_quad(32'h00000000, 32'h01000000, 32'h01000000, 32'h01000000);
    send_quad(32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFE000000);
    send_quad(32'h00000000, 32'h00000000, 32'h00000000, 32'hFFFFFFFF);
    send_quad(32'h00FFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_quad(32'h12345678, 32'h9ABCDEF0, 32'h0F1E2D3C, 32'hC3B4A596);
    directed_quads = quads_sent;

    in_valid <= 1'b0;
    wait_drained();

    for (int q = 0; q < RandomQuads; q++) begin
      if (q % 100 == 0) begin
        calm = ($urandom_range(0, 2) == 0) || (q == 300);
      end
      if (q == 400 || $urandom_range(0, 149) == 0) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      pick_random_quad(q0, q1, q2, q3);
      send_quad(q0, q1, q2, q3);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("summary: %0d quads sent (%0d directed), %0d results compared", quads_sent,
             directed_quads, compared);
    $display("summary: extremes, toe knee, midpoint ties, alpha rounding, flat and random quads");
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/smd_pkg.sv
hw/rtl/smd_linearize.sv
hw/rtl/smd_search_step.sv
hw/rtl/srgb_mip_downsample.sv
dv/mip_checker.sv
dv/tb_top.sv
